// ----- src/rhp_pkg.sv -----
// Package: parser states, output codes, character constants and byte classifiers.
`default_nettype none
package rhp_pkg;

  localparam int unsigned VerW = 10;
  localparam logic [VerW-1:0] VerMax = 10'd999;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChDel   = 8'd127;
  localparam logic [7:0] CtlMax  = 8'd31;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  typedef enum logic [1:0] {
    STATUS_PENDING = 2'd0,
    STATUS_GOOD    = 2'd1,
    STATUS_BAD     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ROLE_OTHER  = 3'd0,
    ROLE_METHOD = 3'd1,
    ROLE_URI    = 3'd2,
    ROLE_HNAME  = 3'd3,
    ROLE_HVALUE = 3'd4
  } role_t;

  typedef enum logic [19:0] {
    ST_METHOD_START = 20'd1 << 0,
    ST_METHOD       = 20'd1 << 1,
    ST_URI          = 20'd1 << 2,
    ST_VER_R        = 20'd1 << 3,
    ST_VER_T        = 20'd1 << 4,
    ST_VER_S        = 20'd1 << 5,
    ST_VER_P        = 20'd1 << 6,
    ST_VER_SLASH    = 20'd1 << 7,
    ST_MAJOR_START  = 20'd1 << 8,
    ST_MAJOR        = 20'd1 << 9,
    ST_MINOR_START  = 20'd1 << 10,
    ST_MINOR        = 20'd1 << 11,
    ST_NL1          = 20'd1 << 12,
    ST_LINE_START   = 20'd1 << 13,
    ST_LWS          = 20'd1 << 14,
    ST_HNAME        = 20'd1 << 15,
    ST_SPACE_BEFORE = 20'd1 << 16,
    ST_HVALUE       = 20'd1 << 17,
    ST_NL2          = 20'd1 << 18,
    ST_NL3          = 20'd1 << 19
  } state_t;

  typedef struct packed {
    state_t          state;
    logic            header_seen;
    logic [VerW-1:0] major;
    logic [VerW-1:0] minor;
  } ctx_t;

  typedef struct packed {
    status_t         status;
    role_t           role;
    logic [7:0]      byte_out;
    logic            header_begin;
    logic            header_commit;
    logic [VerW-1:0] major;
    logic [VerW-1:0] minor;
  } res_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CtlMax) || (c == ChDel);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    logic s;
    unique case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= Ch0) && (c <= Ch9);
  endfunction

  // value*10 + digit, clamped to the version limit
  function automatic logic [VerW-1:0] add_digit(input logic [VerW-1:0] v,
                                                input logic [7:0] c);
    logic [VerW+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VerW{1'b0}}, c[3:0]};
    return (n > {4'b0, VerMax}) ? VerMax : n[VerW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/rhp_step.sv -----
// Per-byte parse step: next parser context and the result fields for one byte.
`default_nettype none
module rhp_step (
  input  var rhp_pkg::ctx_t ctx,
  input  wire logic [7:0]   data_byte,
  input  wire logic         restart,
  output var rhp_pkg::ctx_t ctx_nxt,
  output var rhp_pkg::res_t res
);

  rhp_pkg::ctx_t     c;
  rhp_pkg::status_t  status;
  rhp_pkg::role_t    role;
  logic              hbegin;
  logic              hcommit;
  logic              bad;
  logic              tok;
  logic              ctl;
  logic              dig;
  logic              blank;

  always_comb begin
    c       = ctx;
    status  = rhp_pkg::STATUS_PENDING;
    role    = rhp_pkg::ROLE_OTHER;
    hbegin  = 1'b0;
    hcommit = 1'b0;
    bad     = 1'b0;
    tok     = rhp_pkg::is_token(data_byte);
    ctl     = rhp_pkg::is_ctl(data_byte);
    dig     = rhp_pkg::is_dec_char(data_byte);
    blank   = (data_byte == rhp_pkg::ChSp) || (data_byte == rhp_pkg::ChTab);
    unique case (ctx.state)
      rhp_pkg::ST_METHOD_START: begin
        if (!tok) bad = 1'b1;
        else begin
          c.state = rhp_pkg::ST_METHOD;
          role    = rhp_pkg::ROLE_METHOD;
        end
      end
      rhp_pkg::ST_METHOD: begin
        if (data_byte == rhp_pkg::ChSp) c.state = rhp_pkg::ST_URI;
        else if (!tok) bad = 1'b1;
        else role = rhp_pkg::ROLE_METHOD;
      end
      rhp_pkg::ST_URI: begin
        if (data_byte == rhp_pkg::ChSp) c.state = rhp_pkg::ST_VER_R;
        else if (ctl) bad = 1'b1;
        else role = rhp_pkg::ROLE_URI;
      end
      rhp_pkg::ST_VER_R: begin
        if (data_byte == rhp_pkg::ChR) c.state = rhp_pkg::ST_VER_T;
        else bad = 1'b1;
      end
      rhp_pkg::ST_VER_T: begin
        if (data_byte == rhp_pkg::ChT) c.state = rhp_pkg::ST_VER_S;
        else bad = 1'b1;
      end
      rhp_pkg::ST_VER_S: begin
        if (data_byte == rhp_pkg::ChS) c.state = rhp_pkg::ST_VER_P;
        else bad = 1'b1;
      end
      rhp_pkg::ST_VER_P: begin
        if (data_byte == rhp_pkg::ChP) c.state = rhp_pkg::ST_VER_SLASH;
        else bad = 1'b1;
      end
      rhp_pkg::ST_VER_SLASH: begin
        if (data_byte == rhp_pkg::ChSlash) begin
          c.major = '0;
          c.minor = '0;
          c.state = rhp_pkg::ST_MAJOR_START;
        end else bad = 1'b1;
      end
      rhp_pkg::ST_MAJOR_START: begin
        if (dig) begin
          c.major = rhp_pkg::add_digit(ctx.major, data_byte);
          c.state = rhp_pkg::ST_MAJOR;
        end else bad = 1'b1;
      end
      rhp_pkg::ST_MAJOR: begin
        if (data_byte == rhp_pkg::ChDot) c.state = rhp_pkg::ST_MINOR_START;
        else if (dig) c.major = rhp_pkg::add_digit(ctx.major, data_byte);
        else bad = 1'b1;
      end
      rhp_pkg::ST_MINOR_START: begin
        if (dig) begin
          c.minor = rhp_pkg::add_digit(ctx.minor, data_byte);
          c.state = rhp_pkg::ST_MINOR;
        end else bad = 1'b1;
      end
      rhp_pkg::ST_MINOR: begin
        if (data_byte == rhp_pkg::ChCr) c.state = rhp_pkg::ST_NL1;
        else if (dig) c.minor = rhp_pkg::add_digit(ctx.minor, data_byte);
        else bad = 1'b1;
      end
      rhp_pkg::ST_NL1: begin
        if (data_byte == rhp_pkg::ChLf) c.state = rhp_pkg::ST_LINE_START;
        else bad = 1'b1;
      end
      rhp_pkg::ST_LINE_START: begin
        if (data_byte == rhp_pkg::ChCr) c.state = rhp_pkg::ST_NL3;
        else if (ctx.header_seen && blank) c.state = rhp_pkg::ST_LWS;
        else if (!tok) bad = 1'b1;
        else begin
          c.state = rhp_pkg::ST_HNAME;
          role    = rhp_pkg::ROLE_HNAME;
          hbegin  = 1'b1;
        end
      end
      rhp_pkg::ST_LWS: begin
        if (data_byte == rhp_pkg::ChCr) c.state = rhp_pkg::ST_NL2;
        else if (blank) c.state = rhp_pkg::ST_LWS;
        else if (ctl) bad = 1'b1;
        else begin
          c.state = rhp_pkg::ST_HVALUE;
          role    = rhp_pkg::ROLE_HVALUE;
        end
      end
      rhp_pkg::ST_HNAME: begin
        if (data_byte == rhp_pkg::ChColon) c.state = rhp_pkg::ST_SPACE_BEFORE;
        else if (!tok) bad = 1'b1;
        else role = rhp_pkg::ROLE_HNAME;
      end
      rhp_pkg::ST_SPACE_BEFORE: begin
        if (data_byte == rhp_pkg::ChSp) c.state = rhp_pkg::ST_HVALUE;
        else bad = 1'b1;
      end
      rhp_pkg::ST_HVALUE: begin
        if (data_byte == rhp_pkg::ChCr) begin
          c.header_seen = 1'b1;
          hcommit       = 1'b1;
          c.state       = rhp_pkg::ST_NL2;
        end else if (ctl) bad = 1'b1;
        else role = rhp_pkg::ROLE_HVALUE;
      end
      rhp_pkg::ST_NL2: begin
        if (data_byte == rhp_pkg::ChLf) c.state = rhp_pkg::ST_LINE_START;
        else bad = 1'b1;
      end
      rhp_pkg::ST_NL3: begin
        if (data_byte == rhp_pkg::ChLf) status = rhp_pkg::STATUS_GOOD;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    // a bad byte leaves the context untouched
    if (bad) begin
      c       = ctx;
      status  = rhp_pkg::STATUS_BAD;
      role    = rhp_pkg::ROLE_OTHER;
      hbegin  = 1'b0;
      hcommit = 1'b0;
    end

    if (restart) begin
      ctx_nxt.state       = rhp_pkg::ST_METHOD_START;
      ctx_nxt.header_seen = 1'b0;
      ctx_nxt.major       = '0;
      ctx_nxt.minor       = '0;
      res.status          = rhp_pkg::STATUS_PENDING;
      res.role            = rhp_pkg::ROLE_OTHER;
      res.byte_out        = 8'd0;
      res.header_begin    = 1'b0;
      res.header_commit   = 1'b0;
      res.major           = '0;
      res.minor           = '0;
    end else begin
      ctx_nxt             = c;
      res.status          = status;
      res.role            = role;
      res.byte_out        = data_byte;
      res.header_begin    = hbegin;
      res.header_commit   = hcommit;
      res.major           = c.major;
      res.minor           = c.minor;
    end
  end

endmodule
`default_nettype wire

// ----- src/rtsp_request_head_parser_unit.sv -----
// Top level: RTSP request head parser, one byte beat in, one result beat out.
//
// Takes one byte of an RTSP request head per input beat and returns one result
// beat per byte: status, role tag, echoed byte, header begin/commit marks and
// the running major/minor version (saturating at 999). One byte is accepted
// every cycle while the output register is empty or its beat is taken; each
// result appears in the output register in the cycle after its beat is accepted.
// The parser context register, updated on accept, is the loop that sets this rate.
// The input side keeps accepting while a finished result waits, as long as
// that result is taken in the same cycle. Asserting restart with a beat clears
// the parser; that beat's data byte is ignored and its result is all zeros.
`default_nettype none
module rtsp_request_head_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output wire logic       in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_restart,
  output wire logic       out_valid,
  input  wire logic       out_ready,
  output wire logic [1:0] out_status,
  output wire logic [2:0] out_byte_role,
  output wire logic [7:0] out_byte_out,
  output wire logic       out_header_begin,
  output wire logic       out_header_commit,
  output wire logic [9:0] out_version_major,
  output wire logic [9:0] out_version_minor
);

  rhp_pkg::ctx_t ctx_r;
  rhp_pkg::ctx_t ctx_nxt;
  rhp_pkg::res_t res_r;
  rhp_pkg::res_t res_nxt;
  logic          out_valid_r;
  logic          in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rhp_step u_step (
    .ctx       (ctx_r),
    .data_byte (in_data_byte),
    .restart   (in_restart),
    .ctx_nxt   (ctx_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state       <= rhp_pkg::ST_METHOD_START;
      ctx_r.header_seen <= 1'b0;
      ctx_r.major       <= '0;
      ctx_r.minor       <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        ctx_r <= ctx_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_byte_role     = res_r.role;
  assign out_byte_out      = res_r.byte_out;
  assign out_header_begin  = res_r.header_begin;
  assign out_header_commit = res_r.header_commit;
  assign out_version_major = res_r.major;
  assign out_version_minor = res_r.minor;

endmodule
`default_nettype wire

// ----- src/rhp_checker.sv -----
// Port-level checker for the RTSP request head parser, bound to the top level.
`default_nettype none
module rhp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [2:0] out_byte_role,
  input wire logic       out_header_begin,
  input wire logic       out_header_commit
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before beat taken");

  // an empty output slot never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rhp_pkg::STATUS_BAD |->
      out_byte_role == rhp_pkg::ROLE_OTHER && !out_header_begin && !out_header_commit)
    else $error("bad beat carries role or header mark");

  a_begin_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_begin |->
      out_byte_role == rhp_pkg::ROLE_HNAME && out_status == rhp_pkg::STATUS_PENDING)
    else $error("header begin outside header name");

  a_commit_delim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_commit |->
      out_byte_role == rhp_pkg::ROLE_OTHER && out_status == rhp_pkg::STATUS_PENDING &&
      !out_header_begin)
    else $error("header commit on non-delimiter beat");

endmodule

bind rtsp_request_head_parser_unit rhp_checker u_rhp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_byte_role     (out_byte_role),
  .out_header_begin  (out_header_begin),
  .out_header_commit (out_header_commit)
);
`default_nettype wire
